FILE: design/gfp_pkg.sv
`default_nettype none

package gfp_pkg;

  // Frame layout bytes
  localparam logic [7:0] HDR1_BYTE = 8'hAA;
  localparam logic [7:0] HDR2_BYTE = 8'h55;
  localparam logic [7:0] LEN_BYTE  = 8'd8;
  localparam logic [7:0] CMD_BYTE  = 8'h01;
  localparam logic [7:0] FTR1_BYTE = 8'h0D;
  localparam logic [7:0] FTR2_BYTE = 8'h0A;

  // Result event codes
  localparam logic [1:0] EV_OK       = 2'd0;
  localparam logic [1:0] EV_FRAMING  = 2'd1;
  localparam logic [1:0] EV_CHECKSUM = 2'd2;

  localparam int QUEUE_DEPTH_DEF = 4;

  // Position in the frame: the byte expected next
  typedef enum logic [3:0] {
    POS_HUNT,
    POS_HDR2,
    POS_LEN,
    POS_CMD,
    POS_FWD_HI,
    POS_FWD_LO,
    POS_LAT_HI,
    POS_LAT_LO,
    POS_YAW_HI,
    POS_YAW_LO,
    POS_MODE,
    POS_SUM,
    POS_FTR1,
    POS_FTR2
  } pos_t;

  // Work handed from the front to the back
  typedef enum logic [1:0] {
    ACT_OK,
    ACT_FRAMING,
    ACT_CHECKSUM,
    ACT_CLEAR
  } act_kind_t;

  typedef struct packed {
    logic [15:0] forward;
    logic [15:0] lateral;
    logic [15:0] heading;
    logic [7:0]  mode;
  } vals_t;

  typedef struct packed {
    act_kind_t kind;
    vals_t     vals;
  } act_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] byte_value;
  } req_t;

  typedef struct packed {
    logic [1:0]         event_kind;
    logic signed [15:0] forward_cm;
    logic signed [15:0] lateral_cm;
    logic signed [15:0] heading_centideg;
    logic [7:0]         mode_value;
    logic [31:0]        frames_ok;
    logic [31:0]        errors_seen;
  } res_t;

endpackage

`default_nettype wire

FILE: design/gfp_front.sv
`default_nettype none

module gfp_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire gfp_pkg::req_t req_data,
  input  wire logic          full,
  output logic               push_valid,
  output gfp_pkg::act_t      push_data
);

  gfp_pkg::pos_t  pos, pos_next;
  gfp_pkg::vals_t hold;
  logic [7:0]     sum_running;
  logic [7:0]     sum_received;
  logic           take;
  logic [7:0]     b;

  assign req_ready = !full;
  assign take      = req_valid && !full;
  assign b         = req_data.byte_value;

  // Next position
  always_comb begin
    pos_next = pos;
    if (take && !req_data.cmd) begin
      case (pos)
        gfp_pkg::POS_HDR2:   pos_next = (b == gfp_pkg::HDR2_BYTE) ? gfp_pkg::POS_LEN
                                                                  : gfp_pkg::POS_HUNT;
        gfp_pkg::POS_LEN:    pos_next = (b == gfp_pkg::LEN_BYTE) ? gfp_pkg::POS_CMD
                                                                 : gfp_pkg::POS_HUNT;
        gfp_pkg::POS_CMD:    pos_next = (b == gfp_pkg::CMD_BYTE) ? gfp_pkg::POS_FWD_HI
                                                                 : gfp_pkg::POS_HUNT;
        gfp_pkg::POS_FWD_HI: pos_next = gfp_pkg::POS_FWD_LO;
        gfp_pkg::POS_FWD_LO: pos_next = gfp_pkg::POS_LAT_HI;
        gfp_pkg::POS_LAT_HI: pos_next = gfp_pkg::POS_LAT_LO;
        gfp_pkg::POS_LAT_LO: pos_next = gfp_pkg::POS_YAW_HI;
        gfp_pkg::POS_YAW_HI: pos_next = gfp_pkg::POS_YAW_LO;
        gfp_pkg::POS_YAW_LO: pos_next = gfp_pkg::POS_MODE;
        gfp_pkg::POS_MODE:   pos_next = gfp_pkg::POS_SUM;
        gfp_pkg::POS_SUM:    pos_next = gfp_pkg::POS_FTR1;
        gfp_pkg::POS_FTR1:   pos_next = (b == gfp_pkg::FTR1_BYTE) ? gfp_pkg::POS_FTR2
                                                                  : gfp_pkg::POS_HUNT;
        gfp_pkg::POS_FTR2:   pos_next = gfp_pkg::POS_HUNT;
        default:             pos_next = (b == gfp_pkg::HDR1_BYTE) ? gfp_pkg::POS_HDR2
                                                                  : gfp_pkg::POS_HUNT;
      endcase
    end
  end

  // Classify the request into work for the back
  always_comb begin
    push_valid     = 1'b0;
    push_data.kind = gfp_pkg::ACT_OK;
    push_data.vals = hold;
    if (take) begin
      if (req_data.cmd) begin
        push_valid     = 1'b1;
        push_data.kind = gfp_pkg::ACT_CLEAR;
      end else begin
        case (pos)
          gfp_pkg::POS_HDR2: begin
            push_valid     = (b != gfp_pkg::HDR2_BYTE);
            push_data.kind = gfp_pkg::ACT_FRAMING;
          end
          gfp_pkg::POS_LEN: begin
            push_valid     = (b != gfp_pkg::LEN_BYTE);
            push_data.kind = gfp_pkg::ACT_FRAMING;
          end
          gfp_pkg::POS_CMD: begin
            push_valid     = (b != gfp_pkg::CMD_BYTE);
            push_data.kind = gfp_pkg::ACT_FRAMING;
          end
          gfp_pkg::POS_FTR1: begin
            push_valid     = (b != gfp_pkg::FTR1_BYTE);
            push_data.kind = gfp_pkg::ACT_FRAMING;
          end
          gfp_pkg::POS_FTR2: begin
            push_valid = 1'b1;
            if (b != gfp_pkg::FTR2_BYTE) begin
              push_data.kind = gfp_pkg::ACT_FRAMING;
            end else if (sum_running != sum_received) begin
              push_data.kind = gfp_pkg::ACT_CHECKSUM;
            end else begin
              push_data.kind = gfp_pkg::ACT_OK;
            end
          end
          default: begin
            push_valid = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= gfp_pkg::POS_HUNT;
    end else begin
      pos <= pos_next;
    end
  end

  // Assemble value bytes and the running sum
  always_ff @(posedge clk) begin
    if (take && !req_data.cmd) begin
      case (pos)
        gfp_pkg::POS_LEN: sum_running <= b;
        gfp_pkg::POS_CMD: sum_running <= sum_running + b;
        gfp_pkg::POS_FWD_HI: begin
          hold.forward[15:8] <= b;
          sum_running        <= sum_running + b;
        end
        gfp_pkg::POS_FWD_LO: begin
          hold.forward[7:0] <= b;
          sum_running       <= sum_running + b;
        end
        gfp_pkg::POS_LAT_HI: begin
          hold.lateral[15:8] <= b;
          sum_running        <= sum_running + b;
        end
        gfp_pkg::POS_LAT_LO: begin
          hold.lateral[7:0] <= b;
          sum_running       <= sum_running + b;
        end
        gfp_pkg::POS_YAW_HI: begin
          hold.heading[15:8] <= b;
          sum_running        <= sum_running + b;
        end
        gfp_pkg::POS_YAW_LO: begin
          hold.heading[7:0] <= b;
          sum_running       <= sum_running + b;
        end
        gfp_pkg::POS_MODE: hold.mode    <= b;
        gfp_pkg::POS_SUM:  sum_received <= b;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: design/gfp_queue.sv
`default_nettype none

module gfp_queue #(
  parameter int DEPTH = gfp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push_valid,
  input  wire gfp_pkg::act_t push_data,
  output logic               full,
  input  wire logic          pop,
  output logic               head_valid,
  output gfp_pkg::act_t      head_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  gfp_pkg::act_t    slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == FULL_CNT);
  assign head_valid = (count != '0);
  assign head_data  = slots[rd_ptr];
  assign do_push    = push_valid && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: design/gfp_back.sv
`default_nettype none

module gfp_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire gfp_pkg::act_t head_data,
  output logic               pop,
  output logic               res_valid,
  input  wire logic          res_ready,
  output gfp_pkg::res_t      res_data
);

  logic [31:0]    good_count, good_next;
  logic [31:0]    bad_count, bad_next;
  gfp_pkg::vals_t accepted, accepted_next;
  logic           load;
  logic [1:0]     kind;

  // A clear needs no output slot; results wait for a free one
  assign pop = head_valid &&
               ((head_data.kind == gfp_pkg::ACT_CLEAR) || !res_valid || res_ready);

  always_comb begin
    good_next     = good_count;
    bad_next      = bad_count;
    accepted_next = accepted;
    load          = 1'b0;
    kind          = gfp_pkg::EV_OK;
    if (pop) begin
      case (head_data.kind)
        gfp_pkg::ACT_CLEAR: begin
          good_next = '0;
          bad_next  = '0;
        end
        gfp_pkg::ACT_OK: begin
          good_next     = good_count + 32'd1;
          accepted_next = head_data.vals;
          load          = 1'b1;
          kind          = gfp_pkg::EV_OK;
        end
        gfp_pkg::ACT_FRAMING: begin
          bad_next = bad_count + 32'd1;
          load     = 1'b1;
          kind     = gfp_pkg::EV_FRAMING;
        end
        gfp_pkg::ACT_CHECKSUM: begin
          bad_next = bad_count + 32'd1;
          load     = 1'b1;
          kind     = gfp_pkg::EV_CHECKSUM;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      good_count <= '0;
      bad_count  <= '0;
      accepted   <= '0;
      res_valid  <= 1'b0;
    end else begin
      good_count <= good_next;
      bad_count  <= bad_next;
      accepted   <= accepted_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_data.event_kind       <= kind;
      res_data.forward_cm       <= $signed(accepted_next.forward);
      res_data.lateral_cm       <= $signed(accepted_next.lateral);
      res_data.heading_centideg <= $signed(accepted_next.heading);
      res_data.mode_value       <= accepted_next.mode;
      res_data.frames_ok        <= good_next;
      res_data.errors_seen      <= bad_next;
    end
  end

endmodule

`default_nettype wire

FILE: design/goal_frame_parser_core.sv
// Channel   Direction  Handshake               Payload
// request   in         req_valid / req_ready   req_data  (gfp_pkg::req_t)
// result    out        res_valid / res_ready   res_data  (gfp_pkg::res_t)
//
// One request is taken every cycle while the work queue has room.
// The request that causes a result is written first into the work queue, then
// into the output register of the back once that register is free. The back
// sets the sustained rate: one queue entry a cycle while its output is free.
// Reset clears the frame position, the counters and the latched values.
// A stalled result holds the back; the queue of QUEUE_DEPTH entries then
// fills and req_ready drops.
`default_nettype none

module goal_frame_parser_core #(
  parameter int QUEUE_DEPTH = gfp_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_ready,
  input  wire gfp_pkg::req_t req_data,
  output logic               res_valid,
  input  wire logic          res_ready,
  output gfp_pkg::res_t      res_data
);

  logic          push_valid;
  gfp_pkg::act_t push_data;
  logic          full;
  logic          pop;
  logic          head_valid;
  gfp_pkg::act_t head_data;

  // Front: follow the frame position and classify each request
  gfp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req_data   (req_data),
    .full       (full),
    .push_valid (push_valid),
    .push_data  (push_data)
  );

  // Queue: decouple classification from counting and result delivery
  gfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_data),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data)
  );

  // Back: advance the counters, latch good frames, hold the result
  gfp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_data   (res_data)
  );

endmodule

`default_nettype wire

FILE: design/gfp_checker.sv
`default_nettype none

module gfp_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_valid,
  input wire logic          req_ready,
  input wire logic          res_valid,
  input wire logic          res_ready,
  input wire gfp_pkg::res_t res_data
);

  logic [15:0] pending;

  // Requests taken but not yet matched by a delivered result
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if ((req_valid && req_ready) && !(res_valid && res_ready)) begin
      if (pending != 16'hFFFF) begin
        pending <= pending + 16'd1;
      end
    end else if (!(req_valid && req_ready) && (res_valid && res_ready)) begin
      if (pending != '0) begin
        pending <= pending - 16'd1;
      end
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_data))
    else $error("stalled result changed");

  a_cause: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> pending != '0)
    else $error("result without a request");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_data.event_kind <= gfp_pkg::EV_CHECKSUM)
    else $error("undefined event code");

endmodule

bind goal_frame_parser_core gfp_checker u_gfp_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req_valid),
  .req_ready (req_ready),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res_data  (res_data)
);

`default_nettype wire
